// File: src/swa_pkg.sv
`default_nettype none

package swa_pkg;

	localparam int SAMPLE_W           = 32;
	localparam int DEFAULT_MAX_WINDOW = 64;
	localparam int DEFAULT_FRAC_BITS  = 8;
	localparam int WINDOW_RESET       = 8;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_EVICT = 6'b000100,
		ST_WRITE = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_DONE  = 6'b100000
	} swa_state_t;

endpackage

`default_nettype wire

// File: src/sliding_window_average.sv
// a sample beat passes through the states READ and EVICT (only once the window is full, so that
//   the oldest sample is evicted first), then WRITE, DIV and DONE before its result beat is loaded
// a new sample is taken only after the previous result has been loaded into the output register;
//   the bit-serial divider in DIV makes one quotient bit per cycle over the scaled sum width
// a new input beat is taken while the previous result still waits in the output register
// reset: asynchronous, active low; empties the window, window length 8 (or MAX_WINDOW if smaller), ring not cleared
`default_nettype none

module sliding_window_average
	import swa_pkg::*;
#(
	parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
	parameter int FRAC_BITS  = DEFAULT_FRAC_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]         window_length,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [SAMPLE_W-1:0]              sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [SAMPLE_W+FRAC_BITS-1:0]    mean_q8,
	output logic [$clog2(MAX_WINDOW+1)-1:0]         fill_count
);

	localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
	localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int TOTAL_W = SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int NUM_W   = TOTAL_W + FRAC_BITS;
	localparam int MEAN_W  = SAMPLE_W + FRAC_BITS;
	localparam int RST_WIN = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

	swa_state_t                  state_q;
	logic [CNT_W-1:0]            win_len_q;
	logic [CNT_W-1:0]            win_eff;
	logic [PTR_W-1:0]            oldest_q;
	logic [CNT_W-1:0]            held_q;
	logic signed [TOTAL_W-1:0]   total_q;
	logic signed [SAMPLE_W-1:0]  sample_q;
	logic [SAMPLE_W-1:0]         ring_mem [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0]  rd_data_q;
	logic                        out_valid_q;
	logic [MEAN_W-1:0]           mean_q;
	logic [CNT_W-1:0]            fill_q;

	logic [CNT_W:0]              slot_sum;
	logic [PTR_W-1:0]            slot;
	logic signed [TOTAL_W-1:0]   total_nxt;
	logic signed [NUM_W-1:0]     div_num;
	logic                        ring_we;
	logic                        div_start;
	logic                        div_done;
	logic [MEAN_W-1:0]           div_quo;
	logic                        out_free;

	always_comb begin
		if (win_len_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (win_len_q > CNT_W'(MAX_WINDOW)) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = win_len_q;
		end
	end

	// ring slot after the newest sample, wrapped at the buffer depth
	always_comb begin
		slot_sum = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(held_q);
		if (slot_sum >= (CNT_W+1)'(MAX_WINDOW)) begin
			slot = PTR_W'(slot_sum - (CNT_W+1)'(MAX_WINDOW));
		end else begin
			slot = PTR_W'(slot_sum);
		end
	end

	assign total_nxt = total_q + TOTAL_W'(sample_q);
	assign div_num   = NUM_W'(total_nxt) <<< FRAC_BITS;
	assign ring_we   = (state_q == ST_WRITE);
	assign div_start = (state_q == ST_WRITE);
	assign out_free  = !out_valid_q || out_ready;

	// a config beat takes precedence over a sample beat in idle
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			win_len_q <= CNT_W'(RST_WIN);
			oldest_q  <= '0;
			held_q    <= '0;
			total_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						win_len_q <= window_length;
						oldest_q  <= '0;
						held_q    <= '0;
						total_q   <= '0;
					end else if (in_valid) begin
						state_q <= (held_q >= win_eff) ? ST_READ : ST_WRITE;
					end
				end
				ST_READ: begin
					state_q <= ST_EVICT;
				end
				ST_EVICT: begin
					total_q  <= total_q - TOTAL_W'(rd_data_q);
					held_q   <= held_q - 1'b1;
					oldest_q <= (oldest_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : oldest_q + 1'b1;
					state_q  <= ST_WRITE;
				end
				ST_WRITE: begin
					total_q <= total_nxt;
					held_q  <= held_q + 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// config and input are exclusive in idle; the sample waits there for the ring write
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[slot] <= sample_q;
		end
		rd_data_q <= ring_mem[oldest_q];
	end

	swa_div #(
		.NUM_W (NUM_W),
		.DEN_W (CNT_W),
		.QUO_W (MEAN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (held_q + 1'b1),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			mean_q <= div_quo;
			fill_q <= held_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_q8    = mean_q;
	assign fill_count = fill_q;

`ifndef SYNTH
	a_held_in_window : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (held_q <= win_eff))
		else $error("window holds more samples than its length");
	a_evict_full : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |-> (held_q == win_eff && held_q != '0))
		else $error("eviction from a window that is not full");
	a_fill_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (fill_q != '0 && fill_q <= CNT_W'(MAX_WINDOW)))
		else $error("result beat with a fill count out of range");
	a_div_done_state : assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("quotient finished outside the divide state");
`endif

endmodule

`default_nettype wire

// File: src/swa_div.sv
`default_nettype none

module swa_div #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 7,
	parameter int QUO_W = 40
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DEN_W-1:0] den,
	output logic                    done,
	output logic        [QUO_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] acc_q;
	logic             neg_q;

	logic [DEN_W:0]   trial;
	logic             fits;

	// shift in one numerator bit, subtract the divisor when it fits
	assign trial = {rem_q, acc_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// floor of a negative quotient: divide ~n = |n|-1, then invert the result
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			acc_q <= num[NUM_W-1] ? ~num : num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			acc_q <= {acc_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? ~acc_q[QUO_W-1:0] : acc_q[QUO_W-1:0];

`ifndef SYNTH
	a_start_idle : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_rem_below_den : assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < den_q))
		else $error("partial remainder not below divisor");
	a_done_after_busy : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q))
		else $error("done without a finished division");
`endif

endmodule

`default_nettype wire

// File: verif/tb_sliding_window_average.sv
`timescale 1ns / 100ps

module tb_sliding_window_average;
	import swa_pkg::*;

	localparam int MEAN_W     = SAMPLE_W + DEFAULT_FRAC_BITS;
	localparam int CNT_W      = $clog2(DEFAULT_MAX_WINDOW + 1);
	localparam int PTR_W      = $clog2(DEFAULT_MAX_WINDOW);
	localparam int RAND_ITEMS = 1200;
	localparam int MAX_WAIT   = 18;
	localparam int STALL_CAP  = 2000;
	localparam int TAIL_CYC   = 60;
	localparam int PLAN_LEN   = 29;

	localparam logic ROW_SAMPLE = 1'b0;
	localparam logic ROW_CFG    = 1'b1;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [CNT_W-1:0]  fill;
	} avg_t;

	typedef struct packed {
		logic              kind;
		logic [31:0]       val;
		logic              pinned;
		logic [MEAN_W-1:0] mean;
		logic [CNT_W-1:0]  fill;
	} row_t;

	logic                       clk;
	logic                       arst_n        = 1'b0;
	logic                       cfg_valid     = 1'b0;
	logic                       cfg_ready;
	logic [CNT_W-1:0]           window_length = CNT_W'(WINDOW_RESET);
	logic                       in_valid      = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample        = '0;
	logic                       out_valid;
	logic                       out_ready     = 1'b0;
	logic signed [MEAN_W-1:0]   mean_q8;
	logic [CNT_W-1:0]           fill_count;

	// typed expectation travelling with the input beat
	logic              pin_on   = 1'b0;
	logic [MEAN_W-1:0] pin_mean = '0;
	logic [CNT_W-1:0]  pin_fill = '0;

	// window model
	logic signed [SAMPLE_W-1:0] win_ring [DEFAULT_MAX_WINDOW];
	logic [PTR_W-1:0]           win_head  = '0;
	int                         win_held  = 0;
	longint                     win_total = 0;
	logic [CNT_W-1:0]           win_len   = CNT_W'(WINDOW_RESET);

	avg_t avg_q [$];
	int   fail_count  = 0;
	int   idle_cycles = 0;
	bit   no_idle     = 1'b0;

	row_t plan [PLAN_LEN] = '{
		'{ROW_SAMPLE, 32'h7FFFFFFF, 1'b1, 40'h7FFFFFFF00, 7'd1},
		'{ROW_SAMPLE, 32'h80000000, 1'b1, -40'sd128, 7'd2},
		'{ROW_SAMPLE, 32'hFFFFFFFF, 1'b1, -40'sd171, 7'd3},
		'{ROW_SAMPLE, 32'h00000000, 1'b0, 40'd0, 7'd0},
		'{ROW_CFG, 32'd1, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'h80000000, 1'b1, 40'h8000000000, 7'd1},
		'{ROW_SAMPLE, 32'd5, 1'b1, 40'sd1280, 7'd1},
		// zero length acts as a window of one
		'{ROW_CFG, 32'd0, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'd3, 1'b1, 40'sd768, 7'd1},
		'{ROW_SAMPLE, 32'hFFFFFFFD, 1'b1, -40'sd768, 7'd1},
		'{ROW_CFG, 32'd2, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'd1, 1'b1, 40'sd256, 7'd1},
		'{ROW_SAMPLE, 32'd2, 1'b1, 40'sd384, 7'd2},
		'{ROW_SAMPLE, 32'd4, 1'b1, 40'sd768, 7'd2},
		'{ROW_SAMPLE, 32'hFFFFFFF9, 1'b1, -40'sd384, 7'd2},
		'{ROW_CFG, 32'd3, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'hFFFFFFFF, 1'b1, -40'sd256, 7'd1},
		'{ROW_SAMPLE, 32'h00000000, 1'b1, -40'sd128, 7'd2},
		'{ROW_SAMPLE, 32'h00000000, 1'b1, -40'sd86, 7'd3},
		'{ROW_SAMPLE, 32'd1, 1'b1, 40'sd85, 7'd3},
		// lengths past the ring depth saturate
		'{ROW_CFG, 32'd127, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'h12345678, 1'b0, 40'd0, 7'd0},
		'{ROW_CFG, 32'd65, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'hA5A5A5A5, 1'b0, 40'd0, 7'd0},
		'{ROW_CFG, 32'd64, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'h5A5A5A5A, 1'b0, 40'd0, 7'd0},
		'{ROW_SAMPLE, 32'h80000000, 1'b0, 40'd0, 7'd0}
	};

	sliding_window_average dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_length (window_length),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mean_q8       (mean_q8),
		.fill_count    (fill_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic [31:0] draw_sample();
		case ($urandom_range(0, 7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom();
		endcase
	endfunction

	// advances the window by one sample and returns the floor mean and fill
	function automatic avg_t next_average(input logic signed [SAMPLE_W-1:0] s);
		int               eff;
		logic [PTR_W-1:0] slot;
		longint           num;
		longint           quo;
		avg_t             r;
		if (win_len == 0)
			eff = 1;
		else if (win_len > DEFAULT_MAX_WINDOW)
			eff = DEFAULT_MAX_WINDOW;
		else
			eff = win_len;
		while (win_held >= eff) begin
			win_total -= win_ring[win_head];
			win_head  += 1'b1;
			win_held--;
		end
		slot           = win_head + PTR_W'(win_held);
		win_ring[slot] = s;
		win_held++;
		win_total     += s;
		num = win_total * (64'sd1 <<< DEFAULT_FRAC_BITS);
		quo = num / longint'(win_held);
		if (num < 0 && (num % longint'(win_held)) != 0)
			quo -= 1;
		r.mean = quo[MEAN_W-1:0];
		r.fill = win_held[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin : scoreboard
		avg_t want;
		if (cfg_valid && cfg_ready) begin
			win_len   = window_length;
			win_head  = '0;
			win_held  = 0;
			win_total = 0;
		end
		if (out_valid && out_ready) begin
			if (avg_q.size() == 0) begin
				$error("result beat with no expectation: mean_q8 %0d fill_count %0d",
					mean_q8, fill_count);
				fail_count++;
			end else begin
				want = avg_q.pop_front();
				if (mean_q8 !== want.mean) begin
					$error("mean_q8: expected %0d, actual %0d", $signed(want.mean), mean_q8);
					fail_count++;
				end
				if (fill_count !== want.fill) begin
					$error("fill_count: expected %0d, actual %0d", want.fill, fill_count);
					fail_count++;
				end
			end
		end
		if (in_valid && in_ready) begin
			want = next_average(sample);
			if (pin_on) begin
				want.mean = pin_mean;
				want.fill = pin_fill;
			end
			avg_q.push_back(want);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_CAP) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : result_sink
		int hold;
		@(posedge clk);
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// valid stays up across back-to-back beats so it is never lowered and raised in one step
	task automatic push_sample(input logic [31:0] s, input logic pin,
		input logic [MEAN_W-1:0] m, input logic [CNT_W-1:0] f);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		pin_on   <= pin;
		pin_mean <= m;
		pin_fill <= f;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// the pop of the last result may land in this same step, so look at its beat too
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk);
		while (!(avg_q.size() == 0 || (avg_q.size() == 1 && out_valid && out_ready)));
	endtask

	task automatic write_window(input logic [CNT_W-1:0] w);
		drain_results();
		cfg_valid     <= 1'b1;
		window_length <= w;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int               sent;
		int               phase;
		int               span;
		logic [CNT_W-1:0] w;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].kind == ROW_CFG)
				write_window(plan[i].val[CNT_W-1:0]);
			else
				push_sample(plan[i].val, plan[i].pinned, plan[i].mean, plan[i].fill);
		end

		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			case (phase)
				0: w = CNT_W'(64);
				1: w = CNT_W'(1);
				2: w = CNT_W'(127);
				3: w = CNT_W'(0);
				default:
					case ($urandom_range(0, 9))
						0: w = CNT_W'($urandom_range(65, 127));
						1: w = CNT_W'(0);
						2: w = CNT_W'(64);
						3: w = CNT_W'(1);
						default: w = CNT_W'($urandom_range(1, 64));
					endcase
			endcase
			write_window(w);
			no_idle = ($urandom_range(0, 3) == 0);
			span = $urandom_range(20, 140);
			repeat (span) begin
				if ($urandom_range(0, 39) == 0)
					no_idle = !no_idle;
				push_sample(draw_sample(), 1'b0, '0, '0);
				sent++;
			end
			phase++;
		end

		drain_results();
		repeat (TAIL_CYC) @(posedge clk);
		if (fail_count == 0 && avg_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
